// ===== rtl/pfsr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfsr_pkg
// Shared types, widths and constants of the fixed-spacing path resampler.
// ----------------------------------------------------------------------------
package pfsr_pkg;

    localparam int COORD_WIDTH             = 32;
    localparam int MAX_SAMPLES_PER_SEGMENT = 62;
    localparam int SP_W                    = 24;
    localparam int DIFF_W                  = COORD_WIDTH + 1;
    localparam int PROD_W                  = 2 * DIFF_W;
    localparam int LEN_W                   = DIFF_W;
    localparam int SQRT_STEPS              = PROD_W / 2;
    localparam int REM_W                   = LEN_W + 3;
    localparam int ALONG_W                 = LEN_W + 1;
    localparam int FRAC_W                  = 32;
    localparam int CNT_W                   = 6;
    localparam int STEP_W                  = 6;
    localparam int LIMIT_W                 = SP_W + CNT_W;
    localparam int OFF_W                   = PROD_W - FRAC_W;

    localparam logic [SP_W-1:0]  SPACING_FLOOR = SP_W'(66);
    localparam logic [SP_W-1:0]  SPACING_RESET = SP_W'(6554);
    localparam logic [CNT_W-1:0] SAMPLE_LIMIT  = CNT_W'(MAX_SAMPLES_PER_SEGMENT);

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        logic   path_end;
    } pend_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQX,
        S_SQY,
        S_SUM,
        S_SQRT,
        S_CHECK,
        S_TEST,
        S_DIV,
        S_MX,
        S_MY,
        S_MYW,
        S_EMIT,
        S_FIN,
        S_FLUSH
    } state_t;

endpackage

// ===== rtl/pfsr_vertex_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfsr_vertex_if
// Vertex channel: valid/ready handshake with one path vertex as payload.
// ----------------------------------------------------------------------------
interface pfsr_vertex_if;
    logic                         valid;
    logic                         ready;
    pfsr_pkg::coord_t             point_x;
    pfsr_pkg::coord_t             point_y;
    logic                         final_vertex;

    modport source (output valid, output point_x, output point_y,
                    output final_vertex, input ready);
    modport sink   (input valid, input point_x, input point_y,
                    input final_vertex, output ready);
endinterface

// ----------------------------------------------------------------------------
// pfsr_sample_if
// Sample channel: valid/ready handshake with one resampled point as payload.
// ----------------------------------------------------------------------------
interface pfsr_sample_if;
    logic                         valid;
    logic                         ready;
    pfsr_pkg::coord_t             sample_x;
    pfsr_pkg::coord_t             sample_y;
    logic                         path_end;
    logic                         truncated;

    modport source (output valid, output sample_x, output sample_y,
                    output path_end, output truncated, input ready);
    modport sink   (input valid, input sample_x, input sample_y,
                    input path_end, input truncated, output ready);
endinterface

// ===== rtl/polyline_fixed_spacing_resampler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyline_fixed_spacing_resampler
// Resamples a 2-D path at a fixed arc length with one shared multiplier.
// ----------------------------------------------------------------------------
//  channel   | dir | payload                                    | handshake
//  vertex    | in  | point_x, point_y, final_vertex             | valid/ready
//  sample    | out | sample_x, sample_y, path_end, truncated    | valid/ready
//  wr_*      | in  | wr_data = spacing register (24 bit)        | wr_en
//
//  First vertex: emission, a closing step and a flush, then ready again. A later
//  vertex: squares and sum on the multiplier, the bit-serial root, a check, a
//  final test and the closing steps, then per sample a test, bit-serial fraction
//  division, interpolation and emission; an added endpoint adds one more emission.
//  The root and the per-sample division loop are the longest steps.
//  Reset clears the sequencer, path state and spacing (6554).
//  vertex.ready is high only in idle; a stalled sample holds the sequencer
//  at its next emission, one result waits in the output register.
// ----------------------------------------------------------------------------
module polyline_fixed_spacing_resampler (
    input  logic                      clk,
    input  logic                      rst_n,
    pfsr_vertex_if.sink               vertex,
    pfsr_sample_if.source             sample,
    input  logic                      wr_en,
    input  logic [pfsr_pkg::SP_W-1:0] wr_data
);
    import pfsr_pkg::*;

    state_t                   state_reg, state_next;
    coord_t                   cur_x_reg, cur_x_next, cur_y_reg, cur_y_next;
    logic                     fin_reg, fin_next;
    logic signed [DIFF_W-1:0] dx_reg, dx_next, dy_reg, dy_next;
    logic [PROD_W-1:0]        sq_reg, sq_next, rad_reg, rad_next;
    logic [LEN_W-1:0]         root_reg, root_next, len_reg, len_next;
    logic [REM_W-1:0]         rem_reg, rem_next;
    logic [STEP_W-1:0]        step_reg, step_next;
    logic [ALONG_W-1:0]       along_reg, along_next;
    logic [SP_W-1:0]          carry_reg, carry_next;
    logic                     trunc_reg, trunc_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [LEN_W-1:0]         div_reg, div_next;
    logic [FRAC_W-1:0]        frac_reg, frac_next;
    coord_t                   emit_x_reg, emit_x_next, emit_y_reg, emit_y_next;
    logic                     in_loop_reg, in_loop_next;
    logic                     emitted_reg, emitted_next;
    coord_t                   prev_x_reg, prev_x_next, prev_y_reg, prev_y_next;
    logic                     have_prev_reg, have_prev_next;
    coord_t                   last_x_reg, last_x_next, last_y_reg, last_y_next;
    logic                     pend_valid_reg, pend_valid_next;
    pend_t                    pend_reg, pend_next;
    logic                     out_valid_reg, out_valid_next;
    pend_t                    out_reg, out_next;
    logic                     out_trunc_reg, out_trunc_next;
    logic [SP_W-1:0]          cfg_reg, cfg_next;

    logic [SP_W-1:0]          spacing;
    logic [DIFF_W-1:0]        ax, ay, mul_a, mul_b;
    logic [PROD_W-1:0]        prod;
    logic                     slot_free;
    logic                     out_load;
    logic [REM_W-1:0]         sq_rem, sq_trial;
    logic [LEN_W:0]           div_sh;
    logic [LIMIT_W-1:0]       limit;
    logic [ALONG_W-1:0]       left;
    logic [PROD_W-1:0]        rounded;
    logic [OFF_W-1:0]         off;
    logic [OFF_W-1:0]         base;
    logic [OFF_W-1:0]         coord_sum;

    // clamp spacing and take magnitudes
    assign spacing = (cfg_reg < SPACING_FLOOR) ? SPACING_FLOOR : cfg_reg;
    assign ax = dx_reg[DIFF_W-1] ? DIFF_W'(-dx_reg) : DIFF_W'(dx_reg);
    assign ay = dy_reg[DIFF_W-1] ? DIFF_W'(-dy_reg) : DIFF_W'(dy_reg);

    // select multiplier operands
    always_comb
    begin
        case (state_reg)
            S_SQX:   begin mul_a = ax;                    mul_b = ax; end
            S_SQY:   begin mul_a = ay;                    mul_b = ay; end
            S_MX:    begin mul_a = DIFF_W'(frac_reg);     mul_b = ax; end
            S_MY:    begin mul_a = DIFF_W'(frac_reg);     mul_b = ay; end
            default: begin mul_a = '0;                    mul_b = '0; end
        endcase
    end

    pfsr_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    assign slot_free = !out_valid_reg || sample.ready;
    assign sq_rem    = {rem_reg[REM_W-3:0], rad_reg[PROD_W-1:PROD_W-2]};
    assign sq_trial  = {1'b0, root_reg, 2'b01};
    assign div_sh    = {div_reg, 1'b0};
    assign limit     = LIMIT_W'(carry_reg) + LIMIT_W'(SAMPLE_LIMIT) * LIMIT_W'(spacing);
    assign left      = along_reg - ALONG_W'(len_reg);

    // round the registered product and offset the start point
    assign rounded   = prod + (PROD_W'(1) << (FRAC_W - 1));
    assign off       = rounded[PROD_W-1:FRAC_W];
    assign base      = (state_reg == S_MY) ? OFF_W'(prev_x_reg) : OFF_W'(prev_y_reg);
    always_comb
    begin
        if ((state_reg == S_MY) ? dx_reg[DIFF_W-1] : dy_reg[DIFF_W-1])
            coord_sum = base - off;
        else
            coord_sum = base + off;
    end

    // sequencer and datapath next values
    always_comb
    begin
        state_next      = state_reg;
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        fin_next        = fin_reg;
        dx_next         = dx_reg;
        dy_next         = dy_reg;
        sq_next         = sq_reg;
        rad_next        = rad_reg;
        root_next       = root_reg;
        rem_next        = rem_reg;
        len_next        = len_reg;
        step_next       = step_reg;
        along_next      = along_reg;
        carry_next      = carry_reg;
        trunc_next      = trunc_reg;
        cnt_next        = cnt_reg;
        div_next        = div_reg;
        frac_next       = frac_reg;
        emit_x_next     = emit_x_reg;
        emit_y_next     = emit_y_reg;
        in_loop_next    = in_loop_reg;
        emitted_next    = emitted_reg;
        prev_x_next     = prev_x_reg;
        prev_y_next     = prev_y_reg;
        have_prev_next  = have_prev_reg;
        last_x_next     = last_x_reg;
        last_y_next     = last_y_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_load        = 1'b0;
        cfg_next        = wr_en ? wr_data : cfg_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (vertex.valid)
                begin
                    cur_x_next   = vertex.point_x;
                    cur_y_next   = vertex.point_y;
                    fin_next     = vertex.final_vertex;
                    trunc_next   = 1'b0;
                    emitted_next = 1'b0;
                    dx_next      = DIFF_W'(vertex.point_x) - DIFF_W'(prev_x_reg);
                    dy_next      = DIFF_W'(vertex.point_y) - DIFF_W'(prev_y_reg);
                    if (!have_prev_reg)
                    begin
                        emit_x_next    = vertex.point_x;
                        emit_y_next    = vertex.point_y;
                        in_loop_next   = 1'b0;
                        have_prev_next = 1'b1;
                        carry_next     = spacing;
                        state_next     = S_EMIT;
                    end
                    else
                        state_next = S_SQX;
                end
            end
            S_SQX: state_next = S_SQY;
            S_SQY:
            begin
                sq_next    = prod;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                rad_next   = sq_reg + prod;
                root_next  = '0;
                rem_next   = '0;
                step_next  = '0;
                state_next = S_SQRT;
            end
            // one bit of the root per cycle
            S_SQRT:
            begin
                rad_next = {rad_reg[PROD_W-3:0], 2'b00};
                if (sq_rem >= sq_trial)
                begin
                    rem_next  = sq_rem - sq_trial;
                    root_next = {root_reg[LEN_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = sq_rem;
                    root_next = {root_reg[LEN_W-2:0], 1'b0};
                end
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(SQRT_STEPS - 1))
                begin
                    len_next   = root_next;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (len_reg == '0)
                    state_next = S_FIN;
                else
                begin
                    trunc_next   = LEN_W'(limit) < len_reg;
                    along_next   = ALONG_W'(carry_reg);
                    cnt_next     = '0;
                    in_loop_next = 1'b1;
                    state_next   = S_TEST;
                end
            end
            S_TEST:
            begin
                if ((along_reg < ALONG_W'(len_reg)) && (cnt_reg != SAMPLE_LIMIT))
                begin
                    div_next   = along_reg[LEN_W-1:0];
                    frac_next  = '0;
                    step_next  = '0;
                    state_next = S_DIV;
                end
                else
                begin
                    if (trunc_reg || (left == '0))
                        carry_next = spacing;
                    else
                        carry_next = left[SP_W-1:0];
                    in_loop_next = 1'b0;
                    state_next   = S_FIN;
                end
            end
            // one fraction bit per cycle
            S_DIV:
            begin
                if (div_sh >= {1'b0, len_reg})
                begin
                    div_next  = LEN_W'(div_sh - {1'b0, len_reg});
                    frac_next = {frac_reg[FRAC_W-2:0], 1'b1};
                end
                else
                begin
                    div_next  = div_sh[LEN_W-1:0];
                    frac_next = {frac_reg[FRAC_W-2:0], 1'b0};
                end
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(FRAC_W - 1))
                    state_next = S_MX;
            end
            S_MX: state_next = S_MY;
            S_MY:
            begin
                emit_x_next = coord_sum[COORD_WIDTH-1:0];
                state_next  = S_MYW;
            end
            S_MYW:
            begin
                emit_y_next = coord_sum[COORD_WIDTH-1:0];
                state_next  = S_EMIT;
            end
            // push the held result out and hold the new one
            S_EMIT:
            begin
                if (!pend_valid_reg || slot_free)
                begin
                    out_load        = pend_valid_reg;
                    pend_valid_next = 1'b1;
                    pend_next       = '{x: emit_x_reg, y: emit_y_reg, path_end: 1'b0};
                    last_x_next     = emit_x_reg;
                    last_y_next     = emit_y_reg;
                    emitted_next    = 1'b1;
                    if (in_loop_reg)
                    begin
                        along_next = along_reg + ALONG_W'(spacing);
                        cnt_next   = cnt_reg + CNT_W'(1);
                        state_next = S_TEST;
                    end
                    else
                        state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                prev_x_next = cur_x_reg;
                prev_y_next = cur_y_reg;
                if (fin_reg && (!emitted_reg || last_x_reg != cur_x_reg ||
                                last_y_reg != cur_y_reg))
                begin
                    emit_x_next  = cur_x_reg;
                    emit_y_next  = cur_y_reg;
                    in_loop_next = 1'b0;
                    state_next   = S_EMIT;
                end
                else
                begin
                    if (fin_reg)
                    begin
                        pend_next.path_end = 1'b1;
                        have_prev_next     = 1'b0;
                    end
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                if (!pend_valid_reg)
                    state_next = S_IDLE;
                else if (slot_free)
                begin
                    out_load        = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // output register
    always_comb
    begin
        out_next       = out_reg;
        out_trunc_next = out_trunc_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_next       = pend_reg;
            out_trunc_next = trunc_reg;
        end
        else if (sample.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            prev_x_reg     <= '0;
            prev_y_reg     <= '0;
            have_prev_reg  <= 1'b0;
            carry_reg      <= '0;
            last_x_reg     <= '0;
            last_y_reg     <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            cfg_reg        <= SPACING_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            prev_x_reg     <= prev_x_next;
            prev_y_reg     <= prev_y_next;
            have_prev_reg  <= have_prev_next;
            carry_reg      <= carry_next;
            last_x_reg     <= last_x_next;
            last_y_reg     <= last_y_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            cfg_reg        <= cfg_next;
        end
    end

    // payload and working registers
    always_ff @(posedge clk)
    begin
        cur_x_reg     <= cur_x_next;
        cur_y_reg     <= cur_y_next;
        fin_reg       <= fin_next;
        dx_reg        <= dx_next;
        dy_reg        <= dy_next;
        sq_reg        <= sq_next;
        rad_reg       <= rad_next;
        root_reg      <= root_next;
        rem_reg       <= rem_next;
        len_reg       <= len_next;
        step_reg      <= step_next;
        along_reg     <= along_next;
        trunc_reg     <= trunc_next;
        cnt_reg       <= cnt_next;
        div_reg       <= div_next;
        frac_reg      <= frac_next;
        emit_x_reg    <= emit_x_next;
        emit_y_reg    <= emit_y_next;
        in_loop_reg   <= in_loop_next;
        emitted_reg   <= emitted_next;
        pend_reg      <= pend_next;
        out_reg       <= out_next;
        out_trunc_reg <= out_trunc_next;
    end

    assign vertex.ready     = (state_reg == S_IDLE);
    assign sample.valid     = out_valid_reg;
    assign sample.sample_x  = out_reg.x;
    assign sample.sample_y  = out_reg.y;
    assign sample.path_end  = out_reg.path_end;
    assign sample.truncated = out_trunc_reg;

`ifndef SYNTHESIS
    a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !pend_valid_reg)
        else $error("held result left over in idle");
    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> div_reg < len_reg)
        else $error("division remainder out of range");
    a_cnt_limit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_TEST |-> cnt_reg <= SAMPLE_LIMIT)
        else $error("sample count beyond limit");
    a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EMIT && pend_valid_reg && !slot_free |=> state_reg == S_EMIT)
        else $error("emission left while output blocked");
`endif

endmodule

// ===== rtl/pfsr_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfsr_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module pfsr_mul (
    input  logic                        clk,
    input  logic [pfsr_pkg::DIFF_W-1:0] a,
    input  logic [pfsr_pkg::DIFF_W-1:0] b,
    output logic [pfsr_pkg::PROD_W-1:0] p
);
    import pfsr_pkg::*;

    logic [PROD_W-1:0] p_reg;

    // register the product, one operation a cycle
    always_ff @(posedge clk)
    begin
        p_reg <= PROD_W'(a) * PROD_W'(b);
    end

    assign p = p_reg;

endmodule

// ===== verif/tb_polyline_fixed_spacing_resampler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_polyline_fixed_spacing_resampler
// Self-checking bench for the fixed-spacing path resampler. A directed table
// of vertices covers coordinate extremes, zero-length segments, exact carry,
// truncation and endpoint duplication; random paths follow over several
// spacings. Every emitted sample is compared with an in-bench resampling
// model, with random gaps on both channels and one long output stall.
// ----------------------------------------------------------------------------
module tb_polyline_fixed_spacing_resampler;
    import pfsr_pkg::*;

    localparam int     LIMIT_CYCLES = 4000000;
    localparam int     HOLD_CYCLES  = 3000;
    localparam int     SETTLE       = 300;
    localparam int     NUM_RANDOM   = 147;
    localparam coord_t CMAX         = 32'sh7fffffff;
    localparam coord_t CMIN         = 32'sh80000000;

    typedef struct {
        coord_t x;
        coord_t y;
        logic   path_end;
        logic   truncated;
    } sample_t;

    typedef struct {
        coord_t x;
        coord_t y;
        logic   fin;
        bit     known;
        coord_t ex;
        coord_t ey;
    } vrow_t;

    logic clk;
    logic rst_n;
    logic wr_en;
    logic [SP_W-1:0] wr_data;

    pfsr_vertex_if vtx ();
    pfsr_sample_if smp ();

    polyline_fixed_spacing_resampler u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .vertex  (vtx),
        .sample  (smp),
        .wr_en   (wr_en),
        .wr_data (wr_data)
    );

    // Model state
    coord_t          mdl_prev_x, mdl_prev_y, mdl_last_x, mdl_last_y;
    bit              mdl_have_prev;
    logic [SP_W-1:0] mdl_carry;
    logic [SP_W-1:0] spacing_reg;

    sample_t expected_samples [$];
    sample_t step_samples [$];

    int  fails         = 0;
    int  cycles        = 0;
    int  samples_seen  = 0;
    int  vertices_sent = 0;
    int  trunc_seen    = 0;
    int  spacings_used = 0;
    bit  tx_burst      = 0;
    bit  rx_burst      = 0;
    bit  hold_done     = 0;

    vrow_t directed [0:20] = '{
        '{CMAX, CMIN, 1'b1, 1, CMAX, CMIN},
        '{CMIN, CMAX, 1'b1, 1, CMIN, CMAX},
        '{0, 0, 1'b0, 1, 0, 0},
        '{0, 0, 1'b0, 0, 0, 0},
        '{65536, 0, 1'b0, 0, 0, 0},
        '{65536, 65536, 1'b1, 0, 0, 0},
        '{0, 0, 1'b0, 1, 0, 0},
        '{6554, 0, 1'b0, 0, 0, 0},
        '{13108, 0, 1'b1, 0, 0, 0},
        '{0, 0, 1'b0, 1, 0, 0},
        '{0, 0, 1'b1, 1, 0, 0},
        '{0, 0, 1'b0, 1, 0, 0},
        '{100, -50, 1'b1, 1, 100, -50},
        '{0, 0, 1'b0, 1, 0, 0},
        '{-65536, -30000, 1'b1, 0, 0, 0},
        '{CMIN, CMIN, 1'b0, 1, CMIN, CMIN},
        '{CMAX, CMAX, 1'b1, 0, 0, 0},
        '{0, 0, 1'b0, 1, 0, 0},
        '{CMAX, 0, 1'b0, 0, 0, 0},
        '{CMAX, -1, 1'b1, 0, 0, 0},
        '{0, 0, 1'b0, 1, 0, 0}
    };

    // Clock and cycle limit
    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Append one sample of the current step and remember it as last output
    function automatic void add_sample(input coord_t x, input coord_t y);
        sample_t s;
        s.x = x;
        s.y = y;
        s.path_end = 1'b0;
        s.truncated = 1'b0;
        step_samples = {step_samples, s};
        mdl_last_x = x;
        mdl_last_y = y;
    endfunction

    // Offset of a sample along one axis, magnitude rounded half up
    function automatic coord_t lerp_axis(input coord_t start, input longint d,
                                         input logic [63:0] t);
        logic [127:0] mag;
        logic [127:0] prod;
        longint       off;
        mag = (d < 0) ? 128'(-d) : 128'(d);
        prod = 128'(t) * mag + 128'h8000_0000;
        off = longint'(prod >> 32);
        return (d < 0) ? coord_t'(longint'(start) - off)
                       : coord_t'(longint'(start) + off);
    endfunction

    // Resample one accepted vertex into step_samples and the expected store
    function automatic void resample_vertex(input coord_t x, input coord_t y,
                                            input logic fin);
        longint          dx, dy;
        logic [127:0]    mx, my;
        logic [127:0]    sq, root, rem, trial;
        logic [63:0]     len, along, t;
        logic [SP_W-1:0] sp;
        int              cnt;
        bit              trunc;
        trunc = 0;
        step_samples.delete();
        sp = (spacing_reg < SPACING_FLOOR) ? SPACING_FLOOR : spacing_reg;
        if (!mdl_have_prev)
        begin
            add_sample(x, y);
            mdl_have_prev = 1;
            mdl_carry = sp;
        end
        else
        begin
            dx = longint'(x) - longint'(mdl_prev_x);
            dy = longint'(y) - longint'(mdl_prev_y);
            mx = (dx < 0) ? 128'(-dx) : 128'(dx);
            my = (dy < 0) ? 128'(-dy) : 128'(dy);
            sq = mx * mx + my * my;
            root = 0;
            rem = 0;
            for (int i = 63; i >= 0; i--)
            begin
                rem = (rem << 2) | 128'(sq[2*i +: 2]);
                trial = (root << 2) | 128'd1;
                if (rem >= trial)
                begin
                    rem = rem - trial;
                    root = (root << 1) | 128'd1;
                end
                else
                    root = root << 1;
            end
            len = root[63:0];
            if (len != 0)
            begin
                along = 64'(mdl_carry);
                cnt = 0;
                while (along < len)
                begin
                    if (cnt == MAX_SAMPLES_PER_SEGMENT)
                    begin
                        trunc = 1;
                        break;
                    end
                    t = 64'((128'(along) << 32) / 128'(len));
                    add_sample(lerp_axis(mdl_prev_x, dx, t),
                               lerp_axis(mdl_prev_y, dy, t));
                    along += 64'(sp);
                    cnt++;
                end
                if (trunc)
                    mdl_carry = sp;
                else if (along == len)
                    mdl_carry = sp;
                else
                    mdl_carry = SP_W'(along - len);
            end
        end
        mdl_prev_x = x;
        mdl_prev_y = y;
        if (fin)
        begin
            if (step_samples.size() == 0 || mdl_last_x != x || mdl_last_y != y)
                add_sample(x, y);
            step_samples[step_samples.size()-1].path_end = 1'b1;
            mdl_have_prev = 0;
        end
        foreach (step_samples[k])
        begin
            step_samples[k].truncated = trunc;
            expected_samples = {expected_samples, step_samples[k]};
        end
    endfunction

    // Offer one vertex after a random gap and predict on the transfer
    task automatic push_vertex(input coord_t x, input coord_t y, input logic fin);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 13);
        @(negedge clk);
        if (gap > 0)
        begin
            vtx.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        vtx.valid = 1'b1;
        vtx.point_x = x;
        vtx.point_y = y;
        vtx.final_vertex = fin;
        do @(posedge clk); while (!vtx.ready);
        resample_vertex(x, y, fin);
        vertices_sent++;
    endtask

    // Drain, let the block settle, then write the spacing register
    task automatic set_spacing(input logic [SP_W-1:0] value);
        @(negedge clk);
        vtx.valid = 1'b0;
        while (expected_samples.size() != 0) @(posedge clk);
        repeat (SETTLE) @(negedge clk);
        wr_en = 1'b1;
        wr_data = value;
        spacing_reg = value;
        @(negedge clk);
        wr_en = 1'b0;
        spacings_used++;
    endtask

    // Sample receiver: random stalls, one long hold-off, compare on transfer
    initial
    begin
        int      gap;
        sample_t want;
        smp.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = rx_burst ? 0 : $urandom_range(0, 13);
            @(negedge clk);
            if (!hold_done && samples_seen == 40)
            begin
                hold_done = 1;
                smp.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else if (gap > 0)
            begin
                smp.ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            smp.ready = 1'b1;
            do @(posedge clk); while (!smp.valid);
            samples_seen++;
            if (smp.truncated) trunc_seen++;
            if (expected_samples.size() == 0)
            begin
                $error("unexpected sample x=%0d y=%0d", smp.sample_x, smp.sample_y);
                fails++;
            end
            else
            begin
                want = expected_samples.pop_front();
                if (smp.sample_x !== want.x)
                begin
                    $error("sample_x expected %0d got %0d", want.x, smp.sample_x);
                    fails++;
                end
                if (smp.sample_y !== want.y)
                begin
                    $error("sample_y expected %0d got %0d", want.y, smp.sample_y);
                    fails++;
                end
                if (smp.path_end !== want.path_end)
                begin
                    $error("path_end expected %0b got %0b", want.path_end, smp.path_end);
                    fails++;
                end
                if (smp.truncated !== want.truncated)
                begin
                    $error("truncated expected %0b got %0b",
                           want.truncated, smp.truncated);
                    fails++;
                end
            end
        end
    end

    // Stimulus
    initial
    begin
        logic [SP_W-1:0] sp_list [7];
        int              path_left;
        coord_t          cur_x, cur_y;
        longint          step, sp_eff;
        int              kind;
        logic            fin;

        rst_n = 1'b0;
        wr_en = 1'b0;
        wr_data = '0;
        vtx.valid = 1'b0;
        vtx.point_x = '0;
        vtx.point_y = '0;
        vtx.final_vertex = 1'b0;
        mdl_prev_x = 0;
        mdl_prev_y = 0;
        mdl_last_x = 0;
        mdl_last_y = 0;
        mdl_have_prev = 0;
        mdl_carry = '0;
        spacing_reg = SPACING_RESET;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // Directed table at the reset spacing
        foreach (directed[i])
        begin
            push_vertex(directed[i].x, directed[i].y, directed[i].fin);
            if (directed[i].known &&
                (step_samples[0].x !== directed[i].ex ||
                 step_samples[0].y !== directed[i].ey))
            begin
                $error("row %0d first point expected %0d,%0d", i,
                       directed[i].ex, directed[i].ey);
                fails++;
            end
        end

        // Random paths over several spacings; a path may span a spacing change
        sp_list = '{24'd0, 24'd65, 24'd66, 24'd6554,
                    SP_W'($urandom_range(67, 1000000)), 24'hffffff, 24'd300000};
        path_left = 1;
        cur_x = 0;
        cur_y = 0;
        for (int ph = 0; ph < 7; ph++)
        begin
            set_spacing(sp_list[ph]);
            tx_burst = ($urandom_range(0, 3) == 0);
            rx_burst = ($urandom_range(0, 3) == 0);
            sp_eff = (sp_list[ph] < SPACING_FLOOR) ? 66 : longint'(sp_list[ph]);
            for (int n = 0; n < NUM_RANDOM / 7; n++)
            begin
                kind = $urandom_range(0, 99);
                if (kind >= 95 || !mdl_have_prev && kind < 10)
                begin
                    cur_x = coord_t'($urandom);
                    cur_y = coord_t'($urandom);
                end
                else if (kind >= 8)
                begin
                    step = (kind >= 88) ? 40 * sp_eff : 4 * sp_eff;
                    cur_x = coord_t'(longint'(cur_x) +
                                     longint'($urandom_range(0, 32'(step))) *
                                     ($urandom_range(0, 1) ? 1 : -1));
                    cur_y = coord_t'(longint'(cur_y) +
                                     longint'($urandom_range(0, 32'(step))) *
                                     ($urandom_range(0, 1) ? 1 : -1));
                end
                if (path_left == 0)
                    path_left = $urandom_range(1, 6);
                fin = (path_left == 1);
                path_left--;
                push_vertex(cur_x, cur_y, fin);
            end
        end

        // Close any open path, then drain
        if (mdl_have_prev)
            push_vertex(cur_x, cur_y, 1'b1);
        @(negedge clk);
        vtx.valid = 1'b0;
        while (expected_samples.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("Covered %0d vertices, %0d samples (%0d truncated) over %0d spacings.",
                 vertices_sent, samples_seen, trunc_seen, spacings_used + 1);
        if (fails == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
